[sv/ajb_pkg.sv]
// ----------------------------------------------------------------------------
// ajb_pkg
// Shared types, constants and codes for the adaptive jitter buffer.
// ----------------------------------------------------------------------------
package ajb_pkg;

  localparam int unsigned SLOTS       = 64;
  localparam int unsigned SLOT_AW     = $clog2(SLOTS);
  localparam int unsigned HALF_SLOTS  = SLOTS / 2;
  localparam logic [63:0] MIN_RESET_LATENESS_NS = 64'd16000000;
  localparam logic [7:0]  FADE_SILENT = 8'd150;

  // action codes
  localparam logic [1:0] ACT_PUSH    = 2'd0;
  localparam logic [1:0] ACT_POP     = 2'd1;
  localparam logic [1:0] ACT_RESET   = 2'd2;
  localparam logic [1:0] ACT_INVALID = 2'd3;

  // status codes
  localparam logic [3:0] ST_STORED    = 4'd0;
  localparam logic [3:0] ST_DUP       = 4'd1;
  localparam logic [3:0] ST_LATE      = 4'd2;
  localparam logic [3:0] ST_STARTED   = 4'd3;
  localparam logic [3:0] ST_REBASED   = 4'd4;
  localparam logic [3:0] ST_MALFORMED = 4'd5;
  localparam logic [3:0] ST_REAL      = 4'd6;
  localparam logic [3:0] ST_CONCEALED = 4'd7;
  localparam logic [3:0] ST_SILENCE   = 4'd8;
  localparam logic [3:0] ST_GAP_RESET = 4'd9;
  localparam logic [3:0] ST_NOT_READY = 4'd10;
  localparam logic [3:0] ST_RESET_DONE = 4'd11;

  // register indexes
  localparam logic [2:0] REG_DUR    = 3'd0;
  localparam logic [2:0] REG_FLOOR  = 3'd1;
  localparam logic [2:0] REG_CEIL   = 3'd2;
  localparam logic [2:0] REG_WINDOW = 3'd3;
  localparam logic [2:0] REG_DRIFT  = 3'd4;
  localparam logic [2:0] REG_ADAPT  = 3'd5;
  localparam logic [2:0] REG_RAISE  = 3'd6;
  localparam logic [2:0] REG_LOWER  = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input word
    logic step;     // commit decided update, form result
  } ajb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy_unused;
  } ajb_stat_t;

endpackage

[sv/ajb_ram.sv]
// ----------------------------------------------------------------------------
// ajb_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ajb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[sv/ajb_ctrl.sv]
// ----------------------------------------------------------------------------
// ajb_ctrl
// Sequencer: accept, slot read, decide/commit, present result.
// ----------------------------------------------------------------------------
module ajb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ajb_pkg::ajb_cmd_t cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EXEC = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_READ;
      S_READ:  state_d = S_EXEC;
      S_EXEC:  state_d = S_OUT;
      S_OUT:   if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.step  = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

[sv/ajb_dp.sv]
// ----------------------------------------------------------------------------
// ajb_dp
// Playout state, slot store and the push, pop and reset decision logic.
// ----------------------------------------------------------------------------
module ajb_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ajb_pkg::ajb_cmd_t cmd_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [26:0]       cfg_data_i,
  input  logic [1:0]        action_i,
  input  logic [31:0]       seq_i,
  input  logic [31:0]       handle_i,
  input  logic              len_ok_i,
  input  logic [62:0]       now_i,
  output logic [3:0]        status_o,
  output logic [31:0]       out_handle_o,
  output logic [7:0]        fade_shift_o,
  output logic              dl_valid_o,
  output logic [62:0]       next_dl_o,
  output logic [5:0]        target_o,
  output logic [31:0]       next_seq_o
);
  localparam int unsigned AW = ajb_pkg::SLOT_AW;

  // config
  logic [26:0] dur_q;
  logic [5:0]  floor_q, ceil_q;
  logic [15:0] window_q, drift_q, raise_q, lower_q;
  logic        adapt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q    <= 27'd3000000;
      floor_q  <= 6'd2;
      ceil_q   <= 6'd32;
      window_q <= 16'd256;
      drift_q  <= 16'd50;
      adapt_q  <= 1'b0;
      raise_q  <= 16'd5;
      lower_q  <= 16'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ajb_pkg::REG_DUR:    dur_q    <= cfg_data_i;
        ajb_pkg::REG_FLOOR:  floor_q  <= cfg_data_i[5:0];
        ajb_pkg::REG_CEIL:   ceil_q   <= cfg_data_i[5:0];
        ajb_pkg::REG_WINDOW: window_q <= cfg_data_i[15:0];
        ajb_pkg::REG_DRIFT:  drift_q  <= cfg_data_i[15:0];
        ajb_pkg::REG_ADAPT:  adapt_q  <= cfg_data_i[0];
        ajb_pkg::REG_RAISE:  raise_q  <= cfg_data_i[15:0];
        ajb_pkg::REG_LOWER:  lower_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // captured word
  logic [1:0]  act_q;
  logic [31:0] seq_q, hdl_q;
  logic        ok_q;
  logic [63:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      seq_q <= seq_i;
      hdl_q <= handle_i;
      ok_q  <= len_ok_i;
      now_q <= {1'b0, now_i};
    end
  end

  // playout state
  logic [ajb_pkg::SLOTS-1:0] valid_q, valid_d;
  logic        started_q, started_d;
  logic [31:0] exp_q, exp_d, last_q, last_d;
  logic [63:0] dl_q, dl_d;
  logic [6:0]  consec_q, consec_d;
  logic [15:0] wlate_q, wlate_d, wtot_q, wtot_d, clean_q, clean_d;
  logic [5:0]  target_q, target_d;
  logic [7:0]  fade_q, fade_d;
  logic        alive_q, alive_d;

  // slot RAM: seq and handle in one word; address picked at load
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [63:0]   ram_rd;
  logic [AW-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= (action_i == ajb_pkg::ACT_PUSH) ? seq_i[AW-1:0] : exp_q[AW-1:0];
    end
  end

  ajb_ram #(.Width(64), .Depth(ajb_pkg::SLOTS)) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({seq_q, hdl_q}),
    .rdata_o (ram_rd)
  );
  assign ram_addr = addr_q;

  // registered products (one multiplier each, registered before use);
  // both are formed during the slot read cycle, one from the target and one from the captured word
  logic [63:0] dur_tgt_q, dur_d_q;
  logic [31:0] sd_q;
  always_ff @(posedge clk_i) begin
    dur_tgt_q <= 64'(dur_q) * 64'(target_q);
    sd_q      <= seq_q - exp_q;
    dur_d_q   <= 64'(dur_q) * 64'(6'(seq_q - exp_q));
  end

  // decision
  logic [3:0]  st_d;
  logic [31:0] oh_d;
  logic [7:0]  sh_d;
  logic        hit;
  logic [63:0] dur64, behind, limit, lowered;
  logic [5:0]  ceil_eff, floor_eff;
  logic [15:0] w_eff, dl_eff;
  logic        do_start, do_check, win_rebase;
  logic [15:0] late_snap;

  always_comb begin
    dur64     = 64'(dur_q);
    hit       = valid_q[addr_q] && (ram_rd[63:32] == seq_q);
    ceil_eff  = (ceil_q < 6'(ajb_pkg::HALF_SLOTS)) ? ceil_q : 6'(ajb_pkg::HALF_SLOTS);
    floor_eff = (floor_q != 6'd0) ? floor_q : 6'd1;
    w_eff     = (window_q != 16'd0) ? window_q : 16'd1;
    dl_eff    = (drift_q != 16'd0) ? drift_q : 16'd1;
    limit     = (dur_tgt_q > ajb_pkg::MIN_RESET_LATENESS_NS) ? dur_tgt_q
                                                             : ajb_pkg::MIN_RESET_LATENESS_NS;
    behind    = now_q - dl_q;
    lowered   = dl_q - dur64;

    valid_d = valid_q; started_d = started_q; exp_d = exp_q; last_d = last_q;
    dl_d = dl_q; consec_d = consec_q; wlate_d = wlate_q; wtot_d = wtot_q;
    clean_d = clean_q; target_d = target_q; fade_d = fade_q; alive_d = alive_q;
    st_d = ajb_pkg::ST_NOT_READY; oh_d = '0; sh_d = '0;
    ram_we = 1'b0; do_start = 1'b0; do_check = 1'b0; win_rebase = 1'b0;
    late_snap = '0;

    case (act_q)
      ajb_pkg::ACT_PUSH: begin
        if (!ok_q) begin
          st_d = ajb_pkg::ST_MALFORMED;
        end else if (!started_q) begin
          do_start = 1'b1; st_d = ajb_pkg::ST_STARTED;
        end else if (sd_q[31]) begin
          if (hit) begin
            st_d = ajb_pkg::ST_DUP;
          end else begin
            wlate_d  = (wlate_q != 16'hFFFF) ? wlate_q + 16'd1 : wlate_q;
            wtot_d   = (wtot_q != 16'hFFFF) ? wtot_q + 16'd1 : wtot_q;
            consec_d = consec_q + 7'd1;
            if (consec_d >= 7'(ajb_pkg::SLOTS)) begin
              do_start = 1'b1; st_d = ajb_pkg::ST_REBASED;
            end else begin
              do_check = 1'b1; st_d = ajb_pkg::ST_LATE;
            end
          end
        end else if (sd_q >= 32'(ajb_pkg::SLOTS)) begin
          do_start = 1'b1; st_d = ajb_pkg::ST_REBASED;
        end else begin
          consec_d = '0;
          if (hit) begin
            st_d = ajb_pkg::ST_DUP;
          end else begin
            wtot_d = (wtot_q != 16'hFFFF) ? wtot_q + 16'd1 : wtot_q;
            do_check = 1'b1; st_d = ajb_pkg::ST_STORED; ram_we = 1'b1;
            valid_d[addr_q] = 1'b1;
          end
        end
        // window evaluation
        if (do_check && (wtot_d >= w_eff)) begin
          late_snap = wlate_d;
          wlate_d = '0; wtot_d = '0;
          if (late_snap >= dl_eff) begin
            win_rebase = 1'b1; do_start = 1'b1; st_d = ajb_pkg::ST_REBASED;
          end else if (adapt_q) begin
            if (late_snap >= raise_q) begin
              clean_d = '0;
              if (target_q < ceil_eff) begin
                target_d = target_q + 6'd1; dl_d = dl_q + dur64;
              end
            end else if (late_snap == 16'd0) begin
              clean_d = (clean_q != 16'hFFFF) ? clean_q + 16'd1 : clean_q;
              if (clean_d >= lower_q && target_q > floor_eff) begin
                target_d = target_q - 6'd1;
                dl_d = (lowered - now_q) >> 63 != 64'd0 ? now_q : lowered;
                clean_d = '0;
              end
            end else begin
              clean_d = '0;
            end
          end
        end
        if (do_start) begin
          if (!started_q) begin
            dl_d = now_q + dur_tgt_q;
          end else if (!sd_q[31] && sd_q != 32'd0) begin
            if (sd_q <= 32'(target_q)) dl_d = dl_q + dur_d_q;
            else                       dl_d = now_q + dur_tgt_q;
          end else if (sd_q[31]) begin
            dl_d = dl_q + dur64;
          end else begin
            dl_d = dl_q;
          end
          if (win_rebase) target_d = target_q;
          started_d = 1'b1; exp_d = seq_q; consec_d = '0;
          wlate_d = '0; wtot_d = '0; clean_d = '0;
          ram_we = 1'b1; valid_d[addr_q] = 1'b1;
        end
      end
      ajb_pkg::ACT_POP: begin
        if (!started_q) begin
          st_d = ajb_pkg::ST_NOT_READY;
        end else if (!behind[63] && behind > limit) begin
          valid_d = '0; started_d = 1'b0; exp_d = '0; dl_d = '0; consec_d = '0;
          wlate_d = '0; wtot_d = '0; clean_d = '0; fade_d = '0; alive_d = 1'b0;
          sh_d = ajb_pkg::FADE_SILENT; st_d = ajb_pkg::ST_GAP_RESET;
        end else begin
          if (valid_q[addr_q] && ram_rd[63:32] == exp_q) begin
            last_d = ram_rd[31:0]; valid_d[addr_q] = 1'b0; fade_d = '0;
            alive_d = 1'b1; oh_d = ram_rd[31:0]; st_d = ajb_pkg::ST_REAL;
          end else if (alive_q) begin
            fade_d = fade_q + 8'd1;
            if (fade_d >= ajb_pkg::FADE_SILENT) begin
              fade_d = ajb_pkg::FADE_SILENT; alive_d = 1'b0;
              sh_d = ajb_pkg::FADE_SILENT; st_d = ajb_pkg::ST_SILENCE;
            end else begin
              oh_d = last_q; sh_d = fade_d; st_d = ajb_pkg::ST_CONCEALED;
            end
          end else begin
            sh_d = ajb_pkg::FADE_SILENT; st_d = ajb_pkg::ST_SILENCE;
          end
          exp_d = exp_q + 32'd1;
          dl_d  = dl_q + dur64;
        end
      end
      ajb_pkg::ACT_RESET: begin
        valid_d = '0; started_d = 1'b0; exp_d = '0; dl_d = '0; consec_d = '0;
        wlate_d = '0; wtot_d = '0; clean_d = '0; fade_d = '0; alive_d = 1'b0;
        st_d = ajb_pkg::ST_RESET_DONE;
      end
      default: st_d = ajb_pkg::ST_NOT_READY;
    endcase
    if (!cmd_i.step) ram_we = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0; started_q <= 1'b0; exp_q <= '0; dl_q <= '0;
      consec_q <= '0; wlate_q <= '0; wtot_q <= '0; clean_q <= '0;
      target_q <= 6'd2; fade_q <= '0; alive_q <= 1'b0;
    end else if (cmd_i.step) begin
      valid_q <= valid_d; started_q <= started_d; exp_q <= exp_d; dl_q <= dl_d;
      consec_q <= consec_d; wlate_q <= wlate_d; wtot_q <= wtot_d; clean_q <= clean_d;
      target_q <= target_d; fade_q <= fade_d; alive_q <= alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      last_q       <= last_d;
      status_o     <= st_d;
      out_handle_o <= oh_d;
      fade_shift_o <= sh_d;
    end
  end

  assign dl_valid_o = started_q;
  assign next_dl_o  = started_q ? dl_q[62:0] : 63'd0;
  assign target_o   = target_q;
  assign next_seq_o = exp_q;
endmodule

[sv/adaptive_jitter_buffer_top.sv]
// ----------------------------------------------------------------------------
// adaptive_jitter_buffer_top
// Sequence-numbered reorder store with playout deadline and a target that steps up or down by one.
// ----------------------------------------------------------------------------
// One word is handled at a time in four steps: accept, slot RAM read, decide
// and commit, present. The slot RAM read is registered, and the 27x6 deadline
// multiplies are done in the read cycle and registered before use.
// The result holds until taken; the next word is accepted once it has gone.
// Slot valid bits reset at once, so no clearing pass is needed.
// Configuration is written on any cycle with cfg_we_i high; write only while
// idle.
module adaptive_jitter_buffer_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action[1:0], sequence_req[33:2], payload_handle[65:34], length_ok[66],
  // now_ns[129:67], zero fill to 136
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[3:0], out_handle[35:4], fade_shift[43:36], deadline_valid[44],
  // next_deadline_ns[107:45], target_packets[113:108], next_seq[145:114]
  output logic [151:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [26:0]  cfg_data_i
);
  ajb_pkg::ajb_cmd_t cmd;
  logic [3:0]  st;
  logic [31:0] oh, ns;
  logic [7:0]  sh;
  logic        dv;
  logic [62:0] nd;
  logic [5:0]  tg;

  ajb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  ajb_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .action_i (s_axis_tdata[1:0]),
    .seq_i    (s_axis_tdata[33:2]),
    .handle_i (s_axis_tdata[65:34]),
    .len_ok_i (s_axis_tdata[66]),
    .now_i    (s_axis_tdata[129:67]),
    .status_o (st), .out_handle_o (oh), .fade_shift_o (sh),
    .dl_valid_o (dv), .next_dl_o (nd), .target_o (tg), .next_seq_o (ns)
  );

  assign m_axis_tdata = {6'd0, ns, tg, nd, dv, sh, oh, st};
endmodule

[sv/ajb_checker.sv]
// ----------------------------------------------------------------------------
// ajb_checker
// Port-level checks for the jitter buffer.
// ----------------------------------------------------------------------------
module ajb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [151:0] m_axis_tdata
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> ##2 m_axis_tvalid)
    else $error("result not after three cycles");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[113:108] != 6'd0) else $error("zero target");
endmodule

bind adaptive_jitter_buffer_top ajb_checker u_chk (.*);
